// ===== rtl/core/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int POOL_DEPTH       = 1024;
	localparam int IDX_W            = 10;
	localparam int CNT_W            = 11;
	localparam int REQ_BYTES_W      = 16;
	localparam int BLOCK_BYTES_DEF  = 16;
	localparam int HEADER_BYTES_DEF = 8;

	localparam logic [CNT_W-1:0] LIST_END = CNT_W'(POOL_DEPTH);

	localparam logic FUNC_ALLOC  = 1'b0;
	localparam logic FUNC_FREE   = 1'b1;
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef struct packed {
		logic                   func;
		logic [REQ_BYTES_W-1:0] request_bytes;
		logic [IDX_W-1:0]       release_block;
	} ffa_req_t;

	typedef struct packed {
		logic             status;
		logic [IDX_W-1:0] granted_block;
		logic [CNT_W-1:0] granted_blocks;
	} ffa_rsp_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DIV,
		ST_AL_START,
		ST_AL_EV,
		ST_AL_SP2,
		ST_AL_SP3,
		ST_FR_START,
		ST_FR_WALK,
		ST_FR_EV,
		ST_FR_CHK,
		ST_FR_RDB,
		ST_FR_RDC,
		ST_FR_MG1,
		ST_FR_MG2,
		ST_RESP
	} ffa_state_t;

endpackage

// ===== rtl/core/ffa_stream_if.sv =====
// ----------------------------------------------------------------------------
// ffa_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ffa_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/first_fit_block_allocator.sv =====
// allocate: divide (reciprocal multiply), start, an evaluate step per free run
//   visited, the split states SP2 and SP3 unless the run fits exactly, then the response
// free: start, walk, a step per free run ahead, CHK/RDB/RDC/MG1/MG2 merge, response
// one request at a time; the next beat is taken while a response waits
// after reset or a cfg_wr_en write, the init state rebuilds the list before the first request
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Address-ordered free list of block runs with first-fit allocation,
// splitting and coalescing; list nodes live in two block-indexed memories.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
	parameter int BLOCK_BYTES  = ffa_pkg::BLOCK_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [ffa_pkg::CNT_W-1:0] cfg_wr_data,
	ffa_stream_if.sink               req,
	ffa_stream_if.source             rsp
);
	import ffa_pkg::*;

	localparam int NUM_MAX = (1 << REQ_BYTES_W) - 1 + HEADER_BYTES + BLOCK_BYTES - 1;
	localparam int NUM_W   = $clog2(NUM_MAX + 1);
	localparam int DIV_SH  = NUM_W + $clog2(BLOCK_BYTES);
	localparam int PROD_W  = NUM_W + DIV_SH;
	localparam longint RECIP_L = ((longint'(1) << DIV_SH) + longint'(BLOCK_BYTES) - 1)
		/ longint'(BLOCK_BYTES);

	localparam logic [NUM_W-1:0] NUM_ADD = NUM_W'(HEADER_BYTES + BLOCK_BYTES - 1);
	localparam logic [NUM_W:0]   RECIP   = (NUM_W + 1)'(RECIP_L);

	function automatic logic [CNT_W-1:0] len_room(
		input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] at,
		input logic [CNT_W-1:0] pool
	);
		logic [CNT_W-1:0] room;
		room = pool - at;
		return (v < room) ? v : room;
	endfunction

	// state and payload registers
	ffa_state_t       state_q, state_d;
	logic [CNT_W-1:0] pool_q, pool_d;
	logic [CNT_W-1:0] head_q, head_d;
	logic             out_valid_q, out_valid_d;
	ffa_rsp_t         out_data_q, out_data_d;
	logic [NUM_W-1:0] dq_q, dq_d;
	logic [IDX_W-1:0] pt_q, pt_d;
	logic [NUM_W-1:0] need_q, need_d;
	logic [CNT_W-1:0] prev_q, prev_d;
	logic [CNT_W-1:0] cur_q, cur_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0] steps_q, steps_d;
	logic [CNT_W-1:0] lpt_q, lpt_d;
	logic [CNT_W-1:0] lprev_q, lprev_d;
	logic [CNT_W-1:0] lpost_q, lpost_d;
	logic [CNT_W-1:0] pnext_q, pnext_d;
	logic [IDX_W-1:0] node_q, node_d;
	logic [CNT_W-1:0] nodelen_q, nodelen_d;
	logic             res_status_q, res_status_d;
	logic [IDX_W-1:0] res_block_q, res_block_d;
	logic [CNT_W-1:0] res_blocks_q, res_blocks_d;

	// run memories
	logic [CNT_W-1:0] len_mem [POOL_DEPTH];
	logic [CNT_W-1:0] next_mem [POOL_DEPTH];
	logic [CNT_W-1:0] len_rd_q, next_rd_q;
	logic             len_we, next_we;
	logic [IDX_W-1:0] len_wa, next_wa, len_ra, next_ra;
	logic [CNT_W-1:0] len_wd, next_wd;

	// shared datapath
	logic [CNT_W-1:0]  head_at, rd_next_lim, cl_addr, cl_len, steps_n, cfg_pool, tail_full;
	logic [PROD_W-1:0] div_prod;
	logic [CNT_W:0]    prev_end, node_end;

	assign head_at     = (head_q < pool_q) ? head_q : LIST_END;
	assign rd_next_lim = (next_rd_q < pool_q) ? next_rd_q : LIST_END;
	assign cl_len      = len_room(len_rd_q, cl_addr, pool_q);
	assign steps_n     = steps_q + CNT_W'(1);
	assign tail_full   = cur_q + need_q[CNT_W-1:0];
	// block count by reciprocal multiply, exact over the numerator range
	assign div_prod    = PROD_W'(dq_q) * PROD_W'(RECIP);
	assign prev_end    = {1'b0, prev_q} + {1'b0, lprev_q};
	assign node_end    = {1'b0, 1'b0, node_q} + {1'b0, nodelen_q};

	always_comb begin
		case (state_q)
			ST_FR_RDB: cl_addr = {1'b0, pt_q};
			ST_FR_RDC: cl_addr = prev_q;
			default:   cl_addr = cur_q;
		endcase
	end

	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_pool = CNT_W'(1);
		end else if (cfg_wr_data > LIST_END) begin
			cfg_pool = LIST_END;
		end else begin
			cfg_pool = cfg_wr_data;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	always_comb begin
		state_d      = state_q;
		pool_d       = pool_q;
		head_d       = head_q;
		out_valid_d  = out_valid_q && !rsp.ready;
		out_data_d   = out_data_q;
		dq_d         = dq_q;
		pt_d         = pt_q;
		need_d       = need_q;
		prev_d       = prev_q;
		cur_d        = cur_q;
		tail_d       = tail_q;
		steps_d      = steps_q;
		lpt_d        = lpt_q;
		lprev_d      = lprev_q;
		lpost_d      = lpost_q;
		pnext_d      = pnext_q;
		node_d       = node_q;
		nodelen_d    = nodelen_q;
		res_status_d = res_status_q;
		res_block_d  = res_block_q;
		res_blocks_d = res_blocks_q;
		len_we       = 1'b0;
		len_wa       = '0;
		len_wd       = '0;
		next_we      = 1'b0;
		next_wa      = '0;
		next_wd      = '0;
		len_ra       = cur_q[IDX_W-1:0];
		next_ra      = cur_q[IDX_W-1:0];

		case (state_q)
			ST_INIT: begin
				len_we  = 1'b1;
				len_wa  = '0;
				len_wd  = pool_q;
				next_we = 1'b1;
				next_wa = '0;
				next_wd = LIST_END;
				head_d  = '0;
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) begin
					res_status_d = STATUS_DONE;
					res_block_d  = '0;
					res_blocks_d = '0;
					if (req.data.func == FUNC_ALLOC) begin
						dq_d    = NUM_W'(req.data.request_bytes) + NUM_ADD;
						state_d = ST_DIV;
					end else begin
						pt_d    = req.data.release_block;
						state_d = ST_FR_START;
					end
				end
			end
			ST_DIV: begin
				dq_d    = div_prod[DIV_SH +: NUM_W];
				state_d = ST_AL_START;
			end
			ST_AL_START: begin
				need_d  = (dq_q == '0) ? NUM_W'(1) : dq_q;
				prev_d  = LIST_END;
				cur_d   = head_at;
				steps_d = '0;
				len_ra  = head_at[IDX_W-1:0];
				next_ra = head_at[IDX_W-1:0];
				if (head_at == LIST_END) begin
					res_status_d = STATUS_FAIL;
					state_d      = ST_RESP;
				end else begin
					state_d = ST_AL_EV;
				end
			end
			ST_AL_EV: begin
				if (NUM_W'(cl_len) >= need_q) begin
					res_status_d = STATUS_DONE;
					res_block_d  = cur_q[IDX_W-1:0];
					res_blocks_d = need_q[CNT_W-1:0];
					if (NUM_W'(cl_len) == need_q) begin
						if (prev_q == LIST_END) begin
							head_d = rd_next_lim;
						end else begin
							next_we = 1'b1;
							next_wa = prev_q[IDX_W-1:0];
							next_wd = rd_next_lim;
						end
						len_we  = 1'b1;
						len_wa  = cur_q[IDX_W-1:0];
						len_wd  = need_q[CNT_W-1:0];
						state_d = ST_RESP;
					end else begin
						tail_d  = tail_full[IDX_W-1:0];
						len_we  = 1'b1;
						len_wa  = tail_full[IDX_W-1:0];
						len_wd  = cl_len - need_q[CNT_W-1:0];
						next_we = 1'b1;
						next_wa = tail_full[IDX_W-1:0];
						next_wd = rd_next_lim;
						state_d = ST_AL_SP2;
					end
				end else if (rd_next_lim == LIST_END || steps_n >= pool_q) begin
					res_status_d = STATUS_FAIL;
					state_d      = ST_RESP;
				end else begin
					prev_d  = cur_q;
					cur_d   = rd_next_lim;
					steps_d = steps_n;
					len_ra  = rd_next_lim[IDX_W-1:0];
					next_ra = rd_next_lim[IDX_W-1:0];
				end
			end
			ST_AL_SP2: begin
				if (prev_q == LIST_END) begin
					head_d = {1'b0, tail_q};
				end else begin
					next_we = 1'b1;
					next_wa = prev_q[IDX_W-1:0];
					next_wd = {1'b0, tail_q};
				end
				len_we  = 1'b1;
				len_wa  = cur_q[IDX_W-1:0];
				len_wd  = need_q[CNT_W-1:0];
				state_d = ST_AL_SP3;
			end
			ST_AL_SP3: begin
				next_we = 1'b1;
				next_wa = cur_q[IDX_W-1:0];
				next_wd = LIST_END;
				state_d = ST_RESP;
			end
			ST_FR_START: begin
				if ({1'b0, pt_q} >= pool_q) begin
					state_d = ST_RESP;
				end else if (head_at == LIST_END) begin
					head_d  = {1'b0, pt_q};
					next_we = 1'b1;
					next_wa = pt_q;
					next_wd = LIST_END;
					state_d = ST_RESP;
				end else begin
					prev_d  = LIST_END;
					cur_d   = head_at;
					steps_d = '0;
					state_d = ST_FR_WALK;
				end
			end
			ST_FR_WALK: begin
				if (cur_q != LIST_END && cur_q < {1'b0, pt_q}) begin
					next_ra = cur_q[IDX_W-1:0];
					state_d = ST_FR_EV;
				end else begin
					state_d = ST_FR_CHK;
				end
			end
			ST_FR_EV: begin
				prev_d  = cur_q;
				cur_d   = rd_next_lim;
				steps_d = steps_n;
				if (rd_next_lim != LIST_END && rd_next_lim < {1'b0, pt_q}
						&& steps_n < pool_q) begin
					next_ra = rd_next_lim[IDX_W-1:0];
				end else begin
					state_d = ST_FR_CHK;
				end
			end
			ST_FR_CHK: begin
				len_ra  = pt_q;
				next_ra = cur_q[IDX_W-1:0];
				if (cur_q == {1'b0, pt_q}) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_FR_RDB;
				end
			end
			ST_FR_RDB: begin
				lpt_d   = cl_len;
				pnext_d = rd_next_lim;
				len_ra  = prev_q[IDX_W-1:0];
				state_d = ST_FR_RDC;
			end
			ST_FR_RDC: begin
				lprev_d = cl_len;
				len_ra  = cur_q[IDX_W-1:0];
				state_d = ST_FR_MG1;
			end
			ST_FR_MG1: begin
				lpost_d = cl_len;
				if (prev_q != LIST_END && prev_end == {2'b00, pt_q}) begin
					len_we    = 1'b1;
					len_wa    = prev_q[IDX_W-1:0];
					len_wd    = lprev_q + lpt_q;
					node_d    = prev_q[IDX_W-1:0];
					nodelen_d = lprev_q + lpt_q;
				end else begin
					if (prev_q == LIST_END) begin
						head_d = {1'b0, pt_q};
					end else begin
						next_we = 1'b1;
						next_wa = prev_q[IDX_W-1:0];
						next_wd = {1'b0, pt_q};
					end
					node_d    = pt_q;
					nodelen_d = lpt_q;
				end
				state_d = ST_FR_MG2;
			end
			ST_FR_MG2: begin
				next_we = 1'b1;
				next_wa = node_q;
				if (cur_q != LIST_END && node_end == {1'b0, cur_q}) begin
					len_we  = 1'b1;
					len_wa  = node_q;
					len_wd  = nodelen_q + lpost_q;
					next_wd = pnext_q;
				end else begin
					next_wd = cur_q;
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_d               = 1'b1;
					out_data_d.status         = res_status_q;
					out_data_d.granted_block  = res_block_q;
					out_data_d.granted_blocks = res_blocks_q;
					state_d                   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase

		// pool resize rebuilds the list
		if (cfg_wr_en) begin
			pool_d  = cfg_pool;
			head_d  = '0;
			state_d = ST_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			pool_q      <= LIST_END;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pool_q      <= pool_d;
			head_q      <= head_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_data_q   <= out_data_d;
		dq_q         <= dq_d;
		pt_q         <= pt_d;
		need_q       <= need_d;
		prev_q       <= prev_d;
		cur_q        <= cur_d;
		tail_q       <= tail_d;
		steps_q      <= steps_d;
		lpt_q        <= lpt_d;
		lprev_q      <= lprev_d;
		lpost_q      <= lpost_d;
		pnext_q      <= pnext_d;
		node_q       <= node_d;
		nodelen_q    <= nodelen_d;
		res_status_q <= res_status_d;
		res_block_q  <= res_block_d;
		res_blocks_q <= res_blocks_d;
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_wa] <= len_wd;
		end
		len_rd_q <= len_mem[len_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd_q <= next_mem[next_ra];
	end

endmodule

// ===== rtl/core/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the first-fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffa_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_wr_en,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input ffa_pkg::ffa_rsp_t         rsp_data
);
	import ffa_pkg::*;

	// failed allocate grants nothing
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == STATUS_FAIL
		|-> rsp_data.granted_block == '0 && rsp_data.granted_blocks == '0)
		else $error("failed allocate carries a grant");

	// granted run stays inside the pool memory depth (POOL_DEPTH)
	a_grant_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == STATUS_DONE && rsp_data.granted_blocks != '0
		|-> ({2'b00, rsp_data.granted_block} + {1'b0, rsp_data.granted_blocks})
			<= (CNT_W + 1)'(POOL_DEPTH))
		else $error("granted run runs past the pool");

	// response beat holds while stalled
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response beat changed while stalled");

	// one request at a time
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// ready drops only for a request beat or a pool rebuild
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_ready) |-> $past(req_valid && req_ready) || $past(cfg_wr_en))
		else $error("ready dropped without cause");

endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_wr_en (cfg_wr_en),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ===== verif/tb_first_fit_block_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Self-checking bench for the first-fit block allocator. A shadow free list
// predicts every response from the accepted request beats. Stimulus is a
// directed opening, then random allocate/free traffic over several pool
// sizes. It includes drains that coalesce the pool back into one run, random
// backpressure on both channels, one long response hold-off and one quiet
// stretch.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
	import ffa_pkg::*;

	localparam int BLK_BYTES   = BLOCK_BYTES_DEF;
	localparam int HDR_BYTES   = HEADER_BYTES_DEF;
	localparam int LIST_END_I  = POOL_DEPTH;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1500000;

	logic             clk;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [CNT_W-1:0] cfg_wr_data = '0;
	logic             req_valid   = 1'b0;
	ffa_req_t         req_data    = '0;
	logic             rsp_ready   = 1'b0;

	ffa_stream_if #(.payload_t(ffa_req_t)) req_if ();
	ffa_stream_if #(.payload_t(ffa_rsp_t)) rsp_if ();

	assign req_if.valid = req_valid;
	assign req_if.data  = req_data;
	assign rsp_if.ready = rsp_ready;

	first_fit_block_allocator #(
		.BLOCK_BYTES (BLK_BYTES),
		.HEADER_BYTES(HDR_BYTES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_if),
		.rsp        (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shadow allocator state
	int unsigned      pool_size;
	int unsigned      list_head;
	logic [CNT_W-1:0] run_len  [POOL_DEPTH];
	logic [CNT_W-1:0] run_link [POOL_DEPTH];

	// request beats to send, responses expected, grants seen
	ffa_req_t    req_log[$];
	ffa_rsp_t    exp_log[$];
	int unsigned grant_log[$];
	int unsigned live_runs[$];

	int unsigned issued_count   = 0;
	int unsigned accepted_count = 0;
	int unsigned next_out       = 0;
	int unsigned resp_seen      = 0;
	int unsigned grant_seen     = 0;
	int unsigned hold_asked     = 0;
	int unsigned hold_served    = 0;
	int unsigned hold_left      = 0;
	int unsigned cycle_count    = 0;
	int unsigned err_count      = 0;
	int unsigned n_granted      = 0;
	int unsigned n_refused      = 0;
	int unsigned n_frees        = 0;
	int unsigned n_settings     = 0;
	bit          quiet          = 1'b0;
	ffa_rsp_t    predicted;

	function automatic int unsigned capped_len(int unsigned i);
		int unsigned room;
		int unsigned v;
		room = pool_size - i;
		v = int'(run_len[i]);
		return (v < room) ? v : room;
	endfunction

	function automatic int unsigned link_of(int unsigned i);
		int unsigned v;
		v = int'(run_link[i]);
		return (v < pool_size) ? v : LIST_END_I;
	endfunction

	function automatic int unsigned first_run();
		return (list_head < pool_size) ? list_head : LIST_END_I;
	endfunction

	function automatic void relink(int unsigned prev, int unsigned v);
		if (prev == LIST_END_I) begin
			list_head = v;
		end else begin
			run_link[prev] = CNT_W'(v);
		end
	endfunction

	function automatic void rebuild_pool();
		for (int i = 0; i < POOL_DEPTH; i++) begin
			run_len[i]  = '0;
			run_link[i] = '0;
		end
		list_head   = 0;
		run_len[0]  = CNT_W'(pool_size);
		run_link[0] = LIST_END;
	endfunction

	function automatic void apply_pool_write(logic [CNT_W-1:0] value);
		int unsigned v;
		v = int'(value);
		if (v < 1) v = 1;
		if (v > POOL_DEPTH) v = POOL_DEPTH;
		pool_size = v;
		rebuild_pool();
	endfunction

	function automatic ffa_rsp_t serve_alloc(int unsigned bytes);
		int unsigned need;
		int unsigned prev;
		int unsigned cur;
		int unsigned steps;
		int unsigned len;
		int unsigned tail;
		ffa_rsp_t    r;
		r = '0;
		r.status = STATUS_FAIL;
		need = (bytes + HDR_BYTES + BLK_BYTES - 1) / BLK_BYTES;
		if (need == 0) need = 1;
		prev = LIST_END_I;
		cur = first_run();
		steps = 0;
		while (cur != LIST_END_I && steps < pool_size) begin
			len = capped_len(cur);
			if (len >= need) begin
				if (len == need) begin
					relink(prev, link_of(cur));
				end else begin
					tail = cur + need;
					run_len[tail]  = CNT_W'(len - need);
					run_link[tail] = CNT_W'(link_of(cur));
					relink(prev, tail);
					run_link[cur] = LIST_END;
				end
				run_len[cur] = CNT_W'(need);
				r.status         = STATUS_DONE;
				r.granted_block  = IDX_W'(cur);
				r.granted_blocks = CNT_W'(need);
				return r;
			end
			prev = cur;
			cur = link_of(cur);
			steps++;
		end
		return r;
	endfunction

	function automatic void return_run(int unsigned pt);
		int unsigned prev;
		int unsigned post;
		int unsigned node;
		int unsigned steps;
		if (pt >= pool_size) return;
		prev = LIST_END_I;
		steps = 0;
		post = first_run();
		if (post == LIST_END_I) begin
			list_head = pt;
			run_link[pt] = LIST_END;
			return;
		end
		while (post != LIST_END_I && post < pt && steps < pool_size) begin
			prev = post;
			post = link_of(post);
			steps++;
		end
		if (post == pt) return;
		node = pt;
		if (prev != LIST_END_I && prev + capped_len(prev) == pt) begin
			run_len[prev] = CNT_W'(capped_len(prev) + capped_len(pt));
			node = prev;
		end else begin
			relink(prev, pt);
		end
		if (post != LIST_END_I && node + capped_len(node) == post) begin
			run_len[node]  = CNT_W'(capped_len(node) + capped_len(post));
			run_link[node] = CNT_W'(link_of(post));
		end else begin
			run_link[node] = CNT_W'(post);
		end
	endfunction

	function automatic ffa_rsp_t predict_rsp(ffa_req_t item);
		ffa_rsp_t r;
		if (item.func == FUNC_ALLOC) begin
			r = serve_alloc(int'(item.request_bytes));
			if (r.status == STATUS_DONE) begin
				n_granted++;
			end else begin
				n_refused++;
			end
		end else begin
			return_run(int'(item.release_block));
			n_frees++;
			r = '0;
			r.status = STATUS_DONE;
		end
		return r;
	endfunction

	function automatic int unsigned free_start_pick();
		int unsigned starts[$];
		int unsigned cur;
		int unsigned steps;
		cur = first_run();
		steps = 0;
		while (cur != LIST_END_I && steps < pool_size) begin
			starts.push_back(cur);
			cur = link_of(cur);
			steps++;
		end
		if (starts.size() == 0) return LIST_END_I;
		return starts[$urandom_range(starts.size() - 1)];
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_rsp(ffa_rsp_t got);
		ffa_rsp_t want;
		if (resp_seen >= exp_log.size()) begin
			report_mismatch("response beat with nothing expected");
		end else begin
			want = exp_log[resp_seen];
			if (got.status !== want.status)
				report_mismatch($sformatf("beat %0d status got %0d want %0d",
					resp_seen, got.status, want.status));
			if (got.granted_block !== want.granted_block)
				report_mismatch($sformatf("beat %0d granted_block got %0d want %0d",
					resp_seen, got.granted_block, want.granted_block));
			if (got.granted_blocks !== want.granted_blocks)
				report_mismatch($sformatf("beat %0d granted_blocks got %0d want %0d",
					resp_seen, got.granted_blocks, want.granted_blocks));
			resp_seen++;
		end
	endtask

	// request driver and predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data  <= '0;
			pool_size = POOL_DEPTH;
			rebuild_pool();
		end else begin
			if (cfg_wr_en) begin
				apply_pool_write(cfg_wr_data);
				n_settings++;
			end
			if (req_valid && req_if.ready) begin
				predicted = predict_rsp(req_data);
				exp_log.push_back(predicted);
				if (req_data.func == FUNC_ALLOC && predicted.status == STATUS_DONE)
					grant_log.push_back(int'(predicted.granted_block));
				accepted_count++;
			end
			if (!req_valid || req_if.ready) begin
				if (next_out < req_log.size() && (quiet || $urandom_range(99) >= 30)) begin
					req_data  <= req_log[next_out];
					req_valid <= 1'b1;
					next_out++;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_ready) check_rsp(rsp_if.data);
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= quiet || ($urandom_range(99) >= 30);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d responses still due",
			cycle_count, exp_log.size() - resp_seen);
		$display("== FAIL ==");
		$finish;
	end

	// wait until every issued beat is accepted, then pick up new grants
	task automatic settle();
		while (accepted_count != issued_count) @(posedge clk);
		while (grant_seen < grant_log.size()) begin
			live_runs.push_back(grant_log[grant_seen]);
			grant_seen++;
		end
	endtask

	task automatic wait_responses();
		while (exp_log.size() != resp_seen) @(posedge clk);
	endtask

	task automatic post_alloc(int unsigned bytes);
		ffa_req_t item;
		settle();
		item.func          = FUNC_ALLOC;
		item.request_bytes = REQ_BYTES_W'(bytes);
		item.release_block = IDX_W'($urandom);
		req_log.push_back(item);
		issued_count++;
	endtask

	task automatic post_free(int unsigned blk);
		ffa_req_t item;
		settle();
		for (int i = 0; i < live_runs.size(); i++) begin
			if (live_runs[i] == blk) begin
				live_runs.delete(i);
				break;
			end
		end
		item.func          = FUNC_FREE;
		item.request_bytes = REQ_BYTES_W'($urandom);
		item.release_block = IDX_W'(blk);
		req_log.push_back(item);
		issued_count++;
	endtask

	task automatic write_pool(logic [CNT_W-1:0] value);
		settle();
		wait_responses();
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		live_runs.delete();
		grant_seen = grant_log.size();
	endtask

	task automatic run_directed();
		post_alloc(0);
		post_alloc(8);
		post_alloc(9);
		post_alloc(100);
		post_alloc(65535);
		post_free(1);
		post_free(2);
		post_free(1);
		post_free(4);
		post_free(0);
		post_alloc(16376);
		post_alloc(0);
		post_free(0);
		post_alloc(16360);
		post_alloc(8);
		post_free(1023);
		post_free(0);
		write_pool(11'd0);
		post_alloc(8);
		post_free(1023);
		post_alloc(9);
		post_free(0);
		post_free(0);
		write_pool(11'd2047);
	endtask

	task automatic drain_runs();
		int unsigned k;
		settle();
		while (live_runs.size() != 0) begin
			k = $urandom_range(live_runs.size() - 1);
			post_free(live_runs[k]);
			settle();
		end
	endtask

	task automatic run_phase(int count, int phase);
		int unsigned roll;
		int unsigned maxn;
		int unsigned need;
		int unsigned lo;
		int unsigned hi;
		int unsigned blk;
		for (int k = 0; k < count; k++) begin
			settle();
			if (phase == 0 && k == 60) hold_asked++;
			if (phase == 5 && k == 80) begin
				wait_responses();
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
			roll = $urandom_range(99);
			if (roll >= 50 && roll < 88 && live_runs.size() != 0) begin
				post_free(live_runs[$urandom_range(live_runs.size() - 1)]);
			end else if (roll >= 88 && roll < 94 && free_start_pick() != LIST_END_I) begin
				post_free(free_start_pick());
			end else if (roll >= 94 && pool_size < POOL_DEPTH) begin
				blk = $urandom_range(POOL_DEPTH - 1, pool_size);
				post_free(blk);
			end else if ($urandom_range(19) == 0) begin
				post_alloc($urandom_range(65535));
			end else begin
				maxn = pool_size / 6;
				if (maxn < 1) maxn = 1;
				if (maxn > 48) maxn = 48;
				if ($urandom_range(29) == 0) maxn = pool_size;
				need = $urandom_range(maxn, 1);
				lo = (BLK_BYTES * (need - 1) + 1 > HDR_BYTES) ?
					BLK_BYTES * (need - 1) + 1 - HDR_BYTES : 0;
				hi = BLK_BYTES * need - HDR_BYTES;
				post_alloc($urandom_range(hi, lo));
			end
		end
	endtask

	initial begin : stimulus
		logic [CNT_W-1:0] plan [8];
		plan = '{11'd1024, 11'd40, 11'd1, 11'd2047, 11'd0, 11'd0, 11'd1024, 11'd300};
		plan[5] = CNT_W'($urandom_range(1023, 2));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < 8; p++) begin
			write_pool(plan[p]);
			quiet = (p == 3);
			run_phase(160, p);
			drain_runs();
		end
		quiet = 1'b0;
		settle();
		wait_responses();
		repeat (60) @(posedge clk);
		$display("%0d requests: %0d granted, %0d refused, %0d frees",
			accepted_count, n_granted, n_refused, n_frees);
		$display("%0d pool size writes, %0d mismatches", n_settings, err_count);
		if (err_count == 0 && exp_log.size() == resp_seen) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/ffa_pkg.sv
rtl/core/ffa_stream_if.sv
rtl/core/first_fit_block_allocator.sv
rtl/core/ffa_checker.sv
verif/tb_first_fit_block_allocator.sv
